FILE: design/evb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package evb_pkg;

    // Request and result payloads
    typedef struct packed {
        logic        cmd;
        logic [31:0] event_number;
        logic [3:0]  source_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_event;
        logic        completed;
        logic        last;
    } t_res;

    // Request commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DRAINED   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Widths and limits that do not vary
    localparam int         CNT_W       = 5;
    localparam int         MAX_RESULTS = 16;
    localparam int         DRAIN_W     = 5;
    localparam logic [4:0] SPE_RESET   = 5'd6;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic encode;
        logic update;
        logic emit_empty;
        logic drain;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic drain_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/evb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module evb_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        i_req_cmd,
    input  wire evb_pkg::t_sts i_sts,
    output evb_pkg::t_cmd    o_cmd,
    output logic             busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ENCODE = 5'b00010,
        S_UPDATE = 5'b00100,
        S_EMPTY  = 5'b01000,
        S_DRAIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_cmd == evb_pkg::CMD_ADD) begin
                        n_state = S_ENCODE;
                    end else if (i_sts.fill_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_ENCODE: begin
                o_cmd.encode = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            S_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                n_state          = S_IDLE;
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_sts.drain_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: design/evb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module evb_datapath #(
    parameter int EVENT_SLOTS = 16,
    parameter int MAX_SOURCES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire evb_pkg::t_cmd i_cmd,
    output evb_pkg::t_sts      o_sts,
    input  wire evb_pkg::t_req i_req,
    input  wire logic          i_cfg_valid,
    input  wire logic [4:0]    i_cfg_data,
    output evb_pkg::t_res      o_res,
    output logic               o_strobe
);

    localparam int SW     = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CW     = $clog2(EVENT_SLOTS + 1);
    localparam int MW     = evb_pkg::CNT_W + MAX_SOURCES;
    localparam int QW     = SW + 32;

    // Configuration
    logic [4:0] r_spe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spe <= evb_pkg::SPE_RESET;
        end else if (i_cfg_valid) begin
            r_spe <= i_cfg_data;
        end
    end

    // Latched request
    evb_pkg::t_req r_req;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
    end

    // Slot table: valid bits and event tags (compared in parallel)
    logic [EVENT_SLOTS-1:0] r_valid;
    logic [31:0]            r_event [EVENT_SLOTS];

    // Lookup vectors, registered at accept
    logic [EVENT_SLOTS-1:0] n_hit_vec;
    logic [EVENT_SLOTS-1:0] r_hit_vec;
    logic [EVENT_SLOTS-1:0] r_free_vec;

    always_comb begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
            n_hit_vec[i] = r_valid[i] && (r_event[i] == i_req.event_number);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hit_vec  <= n_hit_vec;
            r_free_vec <= ~r_valid;
        end
    end

    // Lowest matching slot, else lowest free slot
    logic [EVENT_SLOTS-1:0] sel_vec;
    logic [SW-1:0]          enc_idx;
    logic [SW-1:0]          r_slot;
    logic                   r_hit;
    logic                   r_full;

    always_comb begin
        sel_vec = (|r_hit_vec) ? r_hit_vec : r_free_vec;
        enc_idx = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                enc_idx = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.encode) begin
            r_slot <= enc_idx;
            r_hit  <= |r_hit_vec;
            r_full <= ~(|r_hit_vec) & ~(|r_free_vec);
        end
    end

    // Per-slot source mask and count memory: {count, mask}
    logic [MW-1:0] mask_mem [EVENT_SLOTS];
    logic [MW-1:0] r_mask_rd;

    // Completion queue memory: {slot, event}
    logic [QW-1:0] queue_mem [EVENT_SLOTS];
    logic [QW-1:0] r_q_rd;
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [CW-1:0] r_fill;

    // Update step
    logic [MAX_SOURCES-1:0]    src_bit;
    logic [MAX_SOURCES-1:0]    old_mask;
    logic [evb_pkg::CNT_W-1:0] old_cnt;
    logic [evb_pkg::CNT_W-1:0] new_cnt;
    logic                      src_bad;
    logic                      dup;
    logic                      ok;
    logic                      complete;
    logic [2:0]                add_status;

    always_comb begin
        src_bit  = MAX_SOURCES'(1) << r_req.source_id;
        old_mask = r_hit ? r_mask_rd[MAX_SOURCES-1:0] : '0;
        old_cnt  = r_hit ? r_mask_rd[MW-1:MAX_SOURCES] : '0;
        new_cnt  = (old_cnt != {evb_pkg::CNT_W{1'b1}}) ? old_cnt + 1'b1 : old_cnt;
        src_bad  = (32'(r_req.source_id) >= MAX_SOURCES);
        dup      = src_bad || (r_hit && (|(old_mask & src_bit)));
        ok       = !dup && !r_full;
        complete = ok && (new_cnt == r_spe) && (32'(r_fill) < EVENT_SLOTS);
        if (dup) begin
            add_status = evb_pkg::ST_DUPLICATE;
        end else if (r_full) begin
            add_status = evb_pkg::ST_FULL;
        end else begin
            add_status = evb_pkg::ST_ACCEPTED;
        end
    end

    // Drain walk: issue a queue read per cycle, mark it in r_pend, then emit the read data
    logic [evb_pkg::DRAIN_W-1:0] r_left;
    logic                        r_pend;
    logic                        r_pend_last;
    logic                        issue;
    logic [SW-1:0]               drain_slot;

    assign issue      = i_cmd.drain && (r_left != '0);
    assign drain_slot = r_q_rd[QW-1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_left <= (32'(r_fill) > evb_pkg::MAX_RESULTS)
                        ? evb_pkg::DRAIN_W'(evb_pkg::MAX_RESULTS)
                        : evb_pkg::DRAIN_W'(r_fill);
            end else if (issue) begin
                r_left <= r_left - 1'b1;
            end
            r_pend      <= issue;
            r_pend_last <= issue && (r_left == evb_pkg::DRAIN_W'(1));
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        r_mask_rd <= mask_mem[enc_idx];
        if (i_cmd.update && ok) begin
            mask_mem[r_slot] <= {new_cnt, old_mask | src_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_rd <= queue_mem[r_head];
        if (i_cmd.update && complete) begin
            queue_mem[r_tail] <= {r_slot, r_req.event_number};
        end
    end

    // Event tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && ok && !r_hit) begin
            r_event[r_slot] <= r_req.event_number;
        end
    end

    // Valid bits and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cmd.update && ok && !r_hit) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (r_pend) begin
                r_valid[drain_slot] <= 1'b0;
            end
            if (i_cmd.update && complete) begin
                r_tail <= (r_tail == SW'(EVENT_SLOTS - 1)) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end else if (issue) begin
                r_head <= (r_head == SW'(EVENT_SLOTS - 1)) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Result register
    evb_pkg::t_res r_res;
    logic          r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.update || i_cmd.emit_empty || r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res.status       <= add_status;
            r_res.result_event <= r_req.event_number;
            r_res.completed    <= complete;
            r_res.last         <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_res.status       <= evb_pkg::ST_EMPTY;
            r_res.result_event <= '0;
            r_res.completed    <= 1'b0;
            r_res.last         <= 1'b1;
        end else if (r_pend) begin
            r_res.status       <= evb_pkg::ST_DRAINED;
            r_res.result_event <= r_q_rd[31:0];
            r_res.completed    <= 1'b0;
            r_res.last         <= r_pend_last;
        end
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;
    assign o_sts    = '{fill_zero: (r_fill == '0), drain_done: (r_pend && r_pend_last)};

endmodule

`default_nettype wire

FILE: design/event_fragment_builder.sv
// Event fragment builder. Requests are taken when start is high and busy is
// low. An add request runs through accept with parallel tag compare, slot
// select with mask memory read, and update; its single result appears on
// o_res with o_strobe in the cycle in which busy drops. A drain request with
// no completed events gets one ST_EMPTY result; one that drains n events
// (n at most 16) delivers one event per cycle, paced by the single read
// port of the completion queue memory. Results are held for one cycle
// only and the receiver cannot stall them. Configuration writes are always
// ready and must be issued while busy is low and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module event_fragment_builder #(
    parameter int EVENT_SLOTS = 16,
    parameter int MAX_SOURCES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire evb_pkg::t_req i_req,
    output evb_pkg::t_res      o_res,
    output logic               o_strobe,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [4:0]    i_cfg_data
);

    evb_pkg::t_cmd cmd;
    evb_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    evb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_req_cmd (i_req.cmd),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    evb_datapath #(
        .EVENT_SLOTS (EVENT_SLOTS),
        .MAX_SOURCES (MAX_SOURCES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res),
        .o_strobe    (o_strobe)
    );

endmodule

`default_nettype wire
